@@ src/ftach_pkg.sv @@
`timescale 1ns / 1ps
package ftach_pkg;

  localparam int NUM_OUT      = 3;
  localparam int CHANNELS_DEF = 3;
  localparam int HIST_DEF     = 10;
  localparam int QUEUE_DEF    = 2;

  // widths cover the full history depth range (up to 16 entries)
  localparam int CNT_W  = 5;
  localparam int SUM_W  = 20;
  localparam int PROD_W = SUM_W + 8;
  localparam int STEP_W = $clog2(PROD_W);
  localparam int CFG_AW = 4;

  localparam logic [7:0]  DEBOUNCE_RST = 8'd4;
  localparam logic [15:0] WINDOW_RST   = 16'd2000;
  localparam logic [7:0]  SCALE_RST    = 8'd60;

  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_WINDOW   = 2'd1;
  localparam logic [1:0] REG_SCALE    = 2'd2;

  typedef struct packed {
    logic [7:0]  debounce_limit;
    logic [15:0] window_ticks;
    logic [7:0]  rpm_scale;
  } cfg_t;

  // one channel's window summary handed from front to back
  typedef struct packed {
    logic             zero;
    logic [CNT_W-1:0] n;
    logic [SUM_W-1:0] sum;
  } lane_t;

  localparam int LANE_W  = $bits(lane_t);
  localparam int ENTRY_W = LANE_W * NUM_OUT;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } bk_state_t;

endpackage

@@ src/ftach_in_if.sv @@
`timescale 1ns / 1ps
interface ftach_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] tach_levels;

  modport source (output valid, output tach_levels, input ready);
  modport sink (input valid, input tach_levels, output ready);
endinterface

@@ src/ftach_out_if.sv @@
`timescale 1ns / 1ps
interface ftach_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] rpm_ch0;
  logic [15:0] rpm_ch1;
  logic [15:0] rpm_ch2;

  modport source (output valid, output rpm_ch0, output rpm_ch1, output rpm_ch2, input ready);
  modport sink (input valid, input rpm_ch0, input rpm_ch1, input rpm_ch2, output ready);
endinterface

@@ src/ftach_fifo.sv @@
`timescale 1ns / 1ps
module ftach_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("queue count did not advance on push");
`endif

endmodule

@@ src/ftach_front.sv @@
`timescale 1ns / 1ps
module ftach_front #(
  parameter int CHANNELS      = ftach_pkg::CHANNELS_DEF,
  parameter int HISTORY_DEPTH = ftach_pkg::HIST_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  ftach_in_if.sink                     in_ch,
  input  ftach_pkg::cfg_t              cfg,
  output logic                         q_push,
  output logic [ftach_pkg::ENTRY_W-1:0] q_wdata,
  input  logic                         q_full
);
  import ftach_pkg::*;

  logic [15:0] wc_r, wc_nxt;
  logic        wend;
  logic        accept;
  lane_t       entry_w [NUM_OUT];

  // window end depends only on the tick counter and the window length, never on the pin levels
  assign wend        = ({1'b0, wc_r} + 17'd1) >= {1'b0, cfg.window_ticks};
  assign in_ch.ready = !wend || !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign q_push      = accept && wend;

  always_comb begin
    wc_nxt = wc_r;
    if (accept) begin
      wc_nxt = wend ? 16'd0 : wc_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r <= '0;
    end else begin
      wc_r <= wc_nxt;
    end
  end

  for (genvar g = 0; g < NUM_OUT; g++) begin : g_ch
    if (g < CHANNELS) begin : g_on
      logic             await_r, await_nxt;
      logic [7:0]       run_r, run_nxt, run_inc;
      logic [15:0]      cnt_r, cnt_nxt, cnt_dbn;
      logic [15:0]      hist_r [HISTORY_DEPTH];
      logic [15:0]      hist_nxt [HISTORY_DEPTH];
      logic [SUM_W-1:0] sum_r, sum_nxt, sum_sh;
      logic [CNT_W-1:0] n_c;
      logic             level;
      logic             qual;

      assign level = in_ch.tach_levels[g];

      always_comb begin
        run_inc   = (run_r == 8'hFF) ? 8'hFF : run_r + 8'd1;
        qual      = (level == await_r) && (run_inc > cfg.debounce_limit);
        cnt_dbn   = (qual && level && (cnt_r != 16'hFFFF)) ? cnt_r + 16'd1 : cnt_r;
        // sum of the whole history equals the sum from the oldest nonzero entry
        sum_sh    = sum_r - SUM_W'(hist_r[0]) + SUM_W'(cnt_dbn);
        await_nxt = await_r;
        run_nxt   = run_r;
        cnt_nxt   = cnt_r;
        hist_nxt  = hist_r;
        sum_nxt   = sum_r;
        if (accept) begin
          await_nxt = qual ? ~level : await_r;
          run_nxt   = ((level != await_r) || qual) ? 8'd0 : run_inc;
          cnt_nxt   = cnt_dbn;
          if (wend) begin
            cnt_nxt = '0;
            for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
              hist_nxt[i] = hist_r[i+1];
            end
            hist_nxt[HISTORY_DEPTH-1] = cnt_dbn;
            sum_nxt = sum_sh;
          end
        end
      end

      // entries from the oldest nonzero one, seen on the shifted history
      always_comb begin
        n_c = (cnt_dbn != '0) ? CNT_W'(1) : '0;
        for (int i = HISTORY_DEPTH - 2; i >= 0; i--) begin
          if (hist_r[i+1] != '0) begin
            n_c = CNT_W'(HISTORY_DEPTH - i);
          end
        end
      end

      assign entry_w[g] = '{zero: (hist_r[HISTORY_DEPTH-1] == '0) && (cnt_dbn == '0),
                            n: n_c, sum: sum_sh};

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          await_r <= 1'b0;
          run_r   <= '0;
          cnt_r   <= '0;
          hist_r  <= '{default: '0};
          sum_r   <= '0;
        end else begin
          await_r <= await_nxt;
          run_r   <= run_nxt;
          cnt_r   <= cnt_nxt;
          hist_r  <= hist_nxt;
          sum_r   <= sum_nxt;
        end
      end
    end else begin : g_off
      assign entry_w[g] = '{zero: 1'b1, n: '0, sum: '0};
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_OUT; i++) begin
      q_wdata[i*LANE_W +: LANE_W] = entry_w[i];
    end
  end

endmodule

@@ src/ftach_back.sv @@
`timescale 1ns / 1ps
module ftach_back #(
  parameter int CHANNELS = ftach_pkg::CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ftach_pkg::cfg_t               cfg,
  input  logic [ftach_pkg::ENTRY_W-1:0] q_rdata,
  input  logic                          q_empty,
  output logic                          q_pop,
  ftach_out_if.source                   out_ch
);
  import ftach_pkg::*;

  bk_state_t         state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              load_out;
  logic              last_step;
  logic [15:0]       rpm_w [NUM_OUT];

  assign last_step = (step_r == STEP_W'(PROD_W - 1));

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    q_pop     = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          step_nxt  = '0;
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        step_nxt = step_r + STEP_W'(1);
        if (last_step) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        // hold the quotient until the output register frees up
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  for (genvar g = 0; g < NUM_OUT; g++) begin : g_lane
    if (g < CHANNELS) begin : g_on
      lane_t             ln;
      logic [PROD_W-1:0] quo_r, quo_nxt;
      logic [CNT_W-1:0]  rem_r, rem_nxt;
      logic [CNT_W-1:0]  n_r;
      logic              zero_r;
      logic [CNT_W:0]    shifted;
      logic              ge;
      logic [15:0]       rpm_r;

      assign ln = lane_t'(q_rdata[g*LANE_W +: LANE_W]);

      // restoring division, one quotient bit per cycle
      always_comb begin
        shifted = {rem_r, quo_r[PROD_W-1]};
        ge      = shifted >= {1'b0, n_r};
        rem_nxt = ge ? CNT_W'(shifted - {1'b0, n_r}) : shifted[CNT_W-1:0];
        quo_nxt = {quo_r[PROD_W-2:0], ge};
      end

      always_ff @(posedge clk) begin
        if (q_pop) begin
          quo_r  <= PROD_W'(ln.sum) * PROD_W'(cfg.rpm_scale);
          rem_r  <= '0;
          n_r    <= ln.n;
          zero_r <= ln.zero || (ln.n == '0);
        end else if (state_r == BK_DIV) begin
          quo_r <= quo_nxt;
          rem_r <= rem_nxt;
        end
      end

      always_ff @(posedge clk) begin
        if (load_out) begin
          if (zero_r) begin
            rpm_r <= '0;
          end else if (|quo_r[PROD_W-1:16]) begin
            rpm_r <= 16'hFFFF;
          end else begin
            rpm_r <= quo_r[15:0];
          end
        end
      end

      assign rpm_w[g] = rpm_r;
    end else begin : g_off
      assign rpm_w[g] = '0;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.rpm_ch0 = rpm_w[0];
  assign out_ch.rpm_ch1 = rpm_w[1];
  assign out_ch.rpm_ch2 = rpm_w[2];

endmodule

@@ src/fan_tach_rpm_meter.sv @@
`timescale 1ns / 1ps
// channel   direction  beat payload
// in_ch     in         tach_levels[2:0], one sample tick
// out_ch    out        rpm_ch0, rpm_ch1, rpm_ch2, one beat per window end
// cfg_*     in         APB write/read of debounce_limit, window_ticks, rpm_scale
//
// A tick is taken every cycle the front is ready; a window-ending tick also pushes
// a summary into a two-entry queue and stalls only while that queue is full.
// A popped summary goes through the one-bit-per-cycle dividers, one per channel,
// running side by side, and the rpm result is then loaded into the output register.
// Reset is synchronous: counters, debouncers and history clear at once, no sweep.
// A waiting result sits in the output register; the front stalls only once the
// queue behind it has filled.
module fan_tach_rpm_meter #(
  parameter int CHANNELS      = ftach_pkg::CHANNELS_DEF,
  parameter int HISTORY_DEPTH = ftach_pkg::HIST_DEF,
  parameter int QUEUE_DEPTH   = ftach_pkg::QUEUE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ftach_in_if.sink                    in_ch,
  ftach_out_if.source                 out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [ftach_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import ftach_pkg::*;

  cfg_t               cfg_r;
  logic               cfg_wr;
  logic [1:0]         reg_idx;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  logic [ENTRY_W-1:0] q_wdata;
  logic [ENTRY_W-1:0] q_rdata;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_limit <= DEBOUNCE_RST;
      cfg_r.window_ticks   <= WINDOW_RST;
      cfg_r.rpm_scale      <= SCALE_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DEBOUNCE: cfg_r.debounce_limit <= cfg_pwdata[7:0];
        REG_WINDOW:   cfg_r.window_ticks   <= cfg_pwdata[15:0];
        REG_SCALE:    cfg_r.rpm_scale      <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE: cfg_prdata = {24'd0, cfg_r.debounce_limit};
      REG_WINDOW:   cfg_prdata = {16'd0, cfg_r.window_ticks};
      REG_SCALE:    cfg_prdata = {24'd0, cfg_r.rpm_scale};
      default:      cfg_prdata = '0;
    endcase
  end

  ftach_front #(
    .CHANNELS      (CHANNELS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg     (cfg_r),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_full  (q_full)
  );

  ftach_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  ftach_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_rdata (q_rdata),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
